>>> rtl/hotkey_press_repeat_tracker_core_defines.svh
// assertion macros for the tracker rtl
`ifndef HOTKEY_PRESS_REPEAT_TRACKER_CORE_DEFINES_SVH
`define HOTKEY_PRESS_REPEAT_TRACKER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define HPRT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hprt implication check failed");
// next-cycle implication
`define HPRT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hprt next-cycle check failed");
`else
`define HPRT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HPRT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/hprt_pkg.sv
`default_nettype none
package hprt_pkg;

	localparam int NUM_ACTIONS = 32;
	localparam int IDX_W = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1;

	localparam int OP_W = 2;
	localparam int ACT_W = 5;
	localparam int DT_W = 20;
	localparam int CFG_W = 24;
	localparam int HELD_W = 32;
	localparam int REG_IDX_W = 1;
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 16;

	// operation codes
	localparam logic [OP_W-1:0] OP_TICK = 2'd0;
	localparam logic [OP_W-1:0] OP_CONSUME = 2'd1;
	localparam logic [OP_W-1:0] OP_REARM = 2'd2;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_DELAY = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_PERIOD = 1'b1;

	localparam logic [CFG_W-1:0] DELAY_RESET = 24'd275000;
	localparam logic [CFG_W-1:0] PERIOD_RESET = 24'd50000;

	typedef struct packed {
		logic load;
		logic div_start;
		logic commit;
	} hprt_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_busy;
		logic div_last;
		logic out_free;
	} hprt_status_t;

endpackage
`default_nettype wire

>>> rtl/hprt_div.sv
`default_nettype none
// remainder unit, one numerator bit per cycle
module hprt_div (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [hprt_pkg::HELD_W-1:0]    numer,
	input  wire logic [hprt_pkg::CFG_W-1:0]     denom,
	output logic                                busy,
	output logic                                last,
	output logic [hprt_pkg::CFG_W-1:0]          rem
);

	localparam int CNT_W = $clog2(hprt_pkg::HELD_W);

	logic [hprt_pkg::HELD_W-1:0] num_q;
	logic [hprt_pkg::CFG_W-1:0]  denom_q;
	logic [hprt_pkg::CFG_W-1:0]  rem_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        busy_q;
	logic [hprt_pkg::CFG_W:0]    trial;
	logic [hprt_pkg::CFG_W:0]    diff;
	logic                        ge;

	assign trial = {rem_q, num_q[hprt_pkg::HELD_W-1]};
	assign ge = trial >= {1'b0, denom_q};
	assign diff = trial - {1'b0, denom_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_W'(hprt_pkg::HELD_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= numer;
			denom_q <= denom;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= ge ? diff[hprt_pkg::CFG_W-1:0] : trial[hprt_pkg::CFG_W-1:0];
		end
	end

	assign busy = busy_q;
	assign last = busy_q && (cnt_q == '0);
	assign rem = rem_q;

endmodule
`default_nettype wire

>>> rtl/hprt_datapath.sv
`default_nettype none
// per-action state table, item registers, update logic and result register
module hprt_datapath (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire hprt_pkg::hprt_cmd_t                 cmd,
	output hprt_pkg::hprt_status_t                   status,
	input  wire logic [hprt_pkg::OP_W-1:0]           operation,
	input  wire logic [hprt_pkg::ACT_W-1:0]          action_index,
	input  wire logic                                held_raw,
	input  wire logic                                is_keyboard,
	input  wire logic                                window_focused,
	input  wire logic                                capture_active,
	input  wire logic                                text_typing,
	input  wire logic [hprt_pkg::DT_W-1:0]           frame_time_us,
	input  wire logic                                cfg_we,
	input  wire logic [hprt_pkg::REG_IDX_W-1:0]      cfg_index,
	input  wire logic [hprt_pkg::CFG_W-1:0]          cfg_data,
	input  wire logic                                m_tready,
	output logic                                     m_tvalid,
	output logic [hprt_pkg::M_TDATA_W-1:0]           m_tdata
);

	localparam int NA = hprt_pkg::NUM_ACTIONS;
	localparam int HW = hprt_pkg::HELD_W;
	localparam int CW = hprt_pkg::CFG_W;

	// item registers
	logic [hprt_pkg::OP_W-1:0]  op_q;
	logic [hprt_pkg::ACT_W-1:0] act_q;
	logic                       held_q;
	logic                       kbd_q;
	logic                       focus_q;
	logic                       capture_q;
	logic                       typing_q;
	logic [hprt_pkg::DT_W-1:0]  dt_q;

	// configuration
	logic [CW-1:0] delay_q;
	logic [CW-1:0] period_q;

	// state table
	logic [NA-1:0] sup_q;
	logic [NA-1:0] dn_q;
	logic [NA-1:0] pd_q;
	logic [NA-1:0] rp_q;
	logic [HW-1:0] ht_q [NA];

	// result register
	logic                       out_valid_q;
	logic [hprt_pkg::ACT_W-1:0] out_act_q;
	logic                       out_pressed_q;
	logic                       out_por_q;
	logic                       out_down_q;
	logic                       out_cons_q;

	logic [hprt_pkg::IDX_W-1:0] idx;
	logic                       act_ok;
	logic                       sup, dn, pd, rp;
	logic [HW-1:0]              ht;
	logic                       gated, hold_sup, dn_tick, past_delay;
	logic [HW:0]                sum;
	logic [HW-1:0]              ht_sat;
	logic [HW-1:0]              step_full;
	logic [CW-1:0]              period_eff;
	logic [CW-1:0]              rem;
	logic [CW:0]                acc;
	logic                       fire;
	logic                       div_busy, div_last;
	logic                       n_sup, n_dn, n_pd, n_rp, n_cons;
	logic [HW-1:0]              n_ht;
	logic                       n_pressed;

	assign idx = hprt_pkg::IDX_W'(act_q);
	assign act_ok = int'(act_q) < NA;

	assign sup = sup_q[idx];
	assign dn = dn_q[idx];
	assign pd = pd_q[idx];
	assign rp = rp_q[idx];
	assign ht = ht_q[idx];

	assign gated = !focus_q || capture_q || (typing_q && kbd_q);
	assign hold_sup = sup && held_q;
	assign dn_tick = held_q && !gated;

	// saturating held time
	assign sum = {1'b0, ht} + (HW + 1)'(dt_q);
	assign ht_sat = sum[HW] ? '1 : sum[HW-1:0];
	assign past_delay = ht >= HW'(delay_q);

	assign period_eff = (period_q == '0) ? CW'(1) : period_q;

	// repeat fires when ((p - delay) mod period) + added time reaches the period
	assign step_full = ht_sat - ht;
	assign acc = {1'b0, rem} + (CW + 1)'(step_full[hprt_pkg::DT_W-1:0]);
	assign fire = acc >= {1'b0, period_eff};

	hprt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.numer  (ht - HW'(delay_q)),
		.denom  (period_eff),
		.busy   (div_busy),
		.last   (div_last),
		.rem    (rem)
	);

	always_comb begin
		n_sup = sup;
		n_dn = dn;
		n_pd = pd;
		n_rp = rp;
		n_ht = ht;
		n_cons = 1'b0;
		case (op_q)
			hprt_pkg::OP_TICK: begin
				if (hold_sup) begin
					n_dn = 1'b0;
					n_pd = 1'b0;
				end else begin
					n_sup = 1'b0;
					n_pd = dn;
					n_dn = dn_tick;
					n_rp = dn_tick && past_delay && fire;
					n_ht = dn_tick ? ht_sat : '0;
				end
			end
			hprt_pkg::OP_CONSUME: begin
				if (dn && !pd) begin
					n_pd = 1'b1;
					n_cons = 1'b1;
				end
			end
			hprt_pkg::OP_REARM: begin
				n_sup = 1'b1;
				n_dn = 1'b0;
				n_pd = 1'b0;
				n_rp = 1'b0;
				n_ht = '0;
			end
			default: begin
			end
		endcase
	end

	assign n_pressed = n_dn && !n_pd;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= operation;
			act_q <= action_index;
			held_q <= held_raw;
			kbd_q <= is_keyboard;
			focus_q <= window_focused;
			capture_q <= capture_active;
			typing_q <= text_typing;
			dt_q <= frame_time_us;
		end
		if (cmd.commit) begin
			out_act_q <= act_q;
			out_pressed_q <= act_ok && n_pressed;
			out_por_q <= act_ok && (n_pressed || n_rp);
			out_down_q <= act_ok && n_dn;
			out_cons_q <= act_ok && n_cons;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= hprt_pkg::DELAY_RESET;
			period_q <= hprt_pkg::PERIOD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				hprt_pkg::REG_DELAY: delay_q <= cfg_data;
				hprt_pkg::REG_PERIOD: period_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sup_q <= '1;
			dn_q <= '0;
			pd_q <= '0;
			rp_q <= '0;
			for (int i = 0; i < NA; i++) begin
				ht_q[i] <= '0;
			end
		end else if (cmd.commit && act_ok) begin
			sup_q[idx] <= n_sup;
			dn_q[idx] <= n_dn;
			pd_q[idx] <= n_pd;
			rp_q[idx] <= n_rp;
			ht_q[idx] <= n_ht;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.need_div = act_ok && (op_q == hprt_pkg::OP_TICK) && !hold_sup
		&& dn_tick && past_delay;
	assign status.div_busy = div_busy;
	assign status.div_last = div_last;
	assign status.out_free = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata = {7'b0, out_cons_q, out_down_q, out_por_q, out_pressed_q, out_act_q};

endmodule
`default_nettype wire

>>> rtl/hprt_ctrl.sv
`default_nettype none
// item sequencer
module hprt_ctrl (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_tvalid,
	output logic                         s_tready,
	input  wire hprt_pkg::hprt_status_t  status,
	output hprt_pkg::hprt_cmd_t          cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_COMMIT
	} state_t;

	state_t state_q;

	assign s_tready = (state_q == ST_IDLE);
	assign cmd.load = s_tvalid && (state_q == ST_IDLE);
	assign cmd.div_start = (state_q == ST_CHECK) && status.need_div;
	assign cmd.commit = (state_q == ST_COMMIT) && status.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					state_q <= status.need_div ? ST_DIV : ST_COMMIT;
				end
				ST_DIV: begin
					if (status.div_last) state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (status.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> rtl/hotkey_press_repeat_tracker_core.sv
// hotkey press and auto-repeat tracker: keeps edge, suppress, repeat and held-time
// state for each hotkey action and handles one action per input item, returning
// one result item per input item. an item goes through accept, check and commit,
// plus a remainder pass when the action is held past the repeat delay: the repeat
// test needs (held - delay) mod period, from a bit-serial remainder unit at one bit
// per cycle over the 32-bit held time. the next item is accepted as soon as the
// previous one has committed, even while its result still waits in the output
// register. configuration is written through cfg_we / cfg_index / cfg_data (index
// 0 repeat delay, index 1 repeat period, both in microseconds); the user must write
// it only while idle, not enforced by the block; a period of zero behaves as one.
`default_nettype none
`include "hotkey_press_repeat_tracker_core_defines.svh"
module hotkey_press_repeat_tracker_core (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// input items
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	// action_index, held_raw, is_keyboard, window_focused, capture_active,
	// text_typing, frame_time_us, zero fill
	input  wire logic [hprt_pkg::S_TDATA_W-1:0]         s_tdata,
	// operation
	input  wire logic [hprt_pkg::OP_W-1:0]              s_tuser,
	// result items
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	// out_action, pressed, pressed_or_repeated, is_down, consumed, zero fill
	output logic [hprt_pkg::M_TDATA_W-1:0]              m_tdata,
	// configuration writes
	input  wire logic                                   cfg_we,
	input  wire logic [hprt_pkg::REG_IDX_W-1:0]         cfg_index,
	input  wire logic [hprt_pkg::CFG_W-1:0]             cfg_data
);

	hprt_pkg::hprt_cmd_t    cmd;
	hprt_pkg::hprt_status_t status;

	// sequencer: accept, optional remainder pass, commit when the result slot is free
	hprt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// unpack the item fields straight off the bus
	hprt_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.operation      (s_tuser),
		.action_index   (s_tdata[4:0]),
		.held_raw       (s_tdata[5]),
		.is_keyboard    (s_tdata[6]),
		.window_focused (s_tdata[7]),
		.capture_active (s_tdata[8]),
		.text_typing    (s_tdata[9]),
		.frame_time_us  (s_tdata[29:10]),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.m_tready       (m_tready),
		.m_tvalid       (m_tvalid),
		.m_tdata        (m_tdata)
	);

	// a result is only written into a free output slot
	`HPRT_ASSERT_IMP(a_commit_slot_free, clk, arst_n, cmd.commit, !m_tvalid || m_tready)
	// the remainder unit is never restarted while it is working
	`HPRT_ASSERT_IMP(a_div_start_idle, clk, arst_n, cmd.div_start, !status.div_busy)
	// one item in flight: no accept right after an accept
	`HPRT_ASSERT_NXT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready, !s_tready)
	// a committed result shows up on the output
	`HPRT_ASSERT_NXT(a_commit_shows, clk, arst_n, cmd.commit, m_tvalid)

endmodule
`default_nettype wire

>>> tb/sv/hotkey_press_repeat_tracker_core_tb.sv
`default_nettype none
module hotkey_press_repeat_tracker_core_tb;

	// operation code the block does not define; it must leave all state alone
	localparam logic [hprt_pkg::OP_W-1:0] OP_RESERVED = 2'd3;

	localparam int CLK_HALF = 5;
	// room for the slowest item, one with a repeat division, plus handshake slack
	localparam int SETTLE_CYCLES = 60;
	localparam int HOLDOFF_CYCLES = 250;
	localparam int CYCLE_LIMIT = 1_500_000;
	localparam logic [hprt_pkg::DT_W-1:0] DT_MAX = '1;
	localparam logic [hprt_pkg::HELD_W-1:0] HELD_SAT = '1;

	// one input item, unpacked for the stimulus side
	typedef struct packed {
		logic [hprt_pkg::OP_W-1:0]  op;
		logic [hprt_pkg::ACT_W-1:0] act;
		logic                       held;
		logic                       kbd;
		logic                       focus;
		logic                       capture;
		logic                       typing;
		logic [hprt_pkg::DT_W-1:0]  dt;
	} hk_item_t;

	// one result item
	typedef struct packed {
		logic [hprt_pkg::ACT_W-1:0] act;
		logic                       pressed;
		logic                       pressed_or_repeated;
		logic                       down;
		logic                       consumed;
	} hk_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic s_tvalid = 1'b0;
	logic s_tready;
	// action_index, held_raw, is_keyboard, window_focused, capture_active,
	// text_typing, frame_time_us, zero fill
	logic [hprt_pkg::S_TDATA_W-1:0] s_tdata = '0;
	// operation
	logic [hprt_pkg::OP_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// out_action, pressed, pressed_or_repeated, is_down, consumed, zero fill
	logic [hprt_pkg::M_TDATA_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [hprt_pkg::REG_IDX_W-1:0] cfg_index = '0;
	logic [hprt_pkg::CFG_W-1:0] cfg_data = '0;

	hotkey_press_repeat_tracker_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// tracker state as the testbench sees it, one entry per action
	logic                        wait_release [hprt_pkg::NUM_ACTIONS];
	logic                        down_now     [hprt_pkg::NUM_ACTIONS];
	logic                        down_last    [hprt_pkg::NUM_ACTIONS];
	logic                        repeat_now   [hprt_pkg::NUM_ACTIONS];
	logic [hprt_pkg::HELD_W-1:0] held_us      [hprt_pkg::NUM_ACTIONS];
	logic [hprt_pkg::CFG_W-1:0]  delay_cfg;
	logic [hprt_pkg::CFG_W-1:0]  period_cfg;

	// results owed by the block, oldest first
	hk_result_t pending_results[$];

	int mismatches = 0;
	int items_sent = 0;
	int results_seen = 0;
	int repeats_seen = 0;
	int consumes_seen = 0;
	int cycle_count = 0;

	// both sides stop idling while this is set
	logic no_idle = 1'b0;
	// long receiver hold-offs asked for by the tests, and those already done
	int holdoff_req = 0;
	int holdoffs_done = 0;

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// ---------------------------------------------------------------
	// tracker prediction
	// ---------------------------------------------------------------

	task automatic clear_tracker_state();
		for (int i = 0; i < hprt_pkg::NUM_ACTIONS; i++) begin
			wait_release[i] = 1'b1;
			down_now[i] = 1'b0;
			down_last[i] = 1'b0;
			repeat_now[i] = 1'b0;
			held_us[i] = '0;
		end
		delay_cfg = hprt_pkg::DELAY_RESET;
		period_cfg = hprt_pkg::PERIOD_RESET;
	endtask

	// applies one item to the tracker state and returns the result it causes
	function automatic hk_result_t track_action(input hk_item_t it);
		hk_result_t res;
		logic gated;
		logic took;
		logic [hprt_pkg::HELD_W:0] sum;
		logic [hprt_pkg::HELD_W-1:0] before_us;
		logic [hprt_pkg::HELD_W-1:0] delay_us;
		logic [hprt_pkg::HELD_W-1:0] step_us;
		int a;
		a = it.act;
		// an action past the table changes nothing and reports only its index
		if (a >= hprt_pkg::NUM_ACTIONS) begin
			res = '0;
			res.act = it.act;
			return res;
		end
		took = 1'b0;
		delay_us = {8'b0, delay_cfg};
		// a zero period counts as one microsecond
		step_us = (period_cfg == '0) ? 32'd1 : {8'b0, period_cfg};
		case (it.op)
			hprt_pkg::OP_TICK: begin
				if (wait_release[a] && it.held) begin
					// still held since the rearm: keep it released
					down_now[a] = 1'b0;
					down_last[a] = 1'b0;
				end else begin
					wait_release[a] = 1'b0;
					gated = !it.focus || it.capture || (it.typing && it.kbd);
					down_last[a] = down_now[a];
					down_now[a] = it.held && !gated;
					repeat_now[a] = 1'b0;
					if (!down_now[a]) begin
						held_us[a] = '0;
					end else begin
						before_us = held_us[a];
						sum = {1'b0, before_us} + {13'b0, it.dt};
						held_us[a] = sum[hprt_pkg::HELD_W] ? HELD_SAT
							: sum[hprt_pkg::HELD_W-1:0];
						// repeat fires when the repeat count past the delay grows
						if (before_us >= delay_us)
							repeat_now[a] = ((held_us[a] - delay_us) / step_us) >
								((before_us - delay_us) / step_us);
					end
				end
			end
			hprt_pkg::OP_CONSUME: begin
				if (down_now[a] && !down_last[a]) begin
					down_last[a] = 1'b1;
					took = 1'b1;
				end
			end
			hprt_pkg::OP_REARM: begin
				down_now[a] = 1'b0;
				down_last[a] = 1'b0;
				repeat_now[a] = 1'b0;
				held_us[a] = '0;
				wait_release[a] = 1'b1;
			end
			default: begin
				// reserved code: state stays as it is
			end
		endcase
		res.act = it.act;
		res.pressed = down_now[a] && !down_last[a];
		res.pressed_or_repeated = res.pressed || repeat_now[a];
		res.down = down_now[a];
		res.consumed = took;
		return res;
	endfunction

	// ---------------------------------------------------------------
	// input side
	// ---------------------------------------------------------------

	function automatic logic rnd_bit();
		return 1'($urandom_range(0, 1));
	endfunction

	function automatic hk_item_t build_item(input logic [hprt_pkg::OP_W-1:0] op,
		input logic [hprt_pkg::ACT_W-1:0] act, input logic held, input logic kbd,
		input logic focus, input logic capture, input logic typing,
		input logic [hprt_pkg::DT_W-1:0] dt);
		hk_item_t it;
		it.op = op;
		it.act = act;
		it.held = held;
		it.kbd = kbd;
		it.focus = focus;
		it.capture = capture;
		it.typing = typing;
		it.dt = dt;
		return it;
	endfunction

	// offers one item and returns right after the edge that takes it;
	// tvalid stays high so the next item can follow without a gap
	task automatic send_item(input hk_item_t it);
		if (!no_idle && $urandom_range(0, 99) < 8) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat ($urandom_range(0, 3)) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= it.op;
		s_tdata <= {2'b0, it.dt, it.typing, it.capture, it.focus, it.kbd, it.held,
			it.act};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		// taken at this edge: predict in acceptance order
		pending_results.push_back(track_action(it));
		items_sent++;
	endtask

	// stops offering and waits until the block owes nothing and has gone quiet
	task automatic quiesce();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_timing(input logic [hprt_pkg::CFG_W-1:0] delay_us,
		input logic [hprt_pkg::CFG_W-1:0] period_us);
		quiesce();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= hprt_pkg::REG_DELAY;
		cfg_data <= delay_us;
		@(negedge clk);
		cfg_index <= hprt_pkg::REG_PERIOD;
		cfg_data <= period_us;
		@(negedge clk);
		cfg_we <= 1'b0;
		delay_cfg = delay_us;
		period_cfg = period_us;
	endtask

	// mostly press-hold-release runs on one action, with some random noise
	task automatic run_sequences(input int n_items);
		int stop_at;
		int len;
		int dt_hi;
		logic [hprt_pkg::ACT_W-1:0] act;
		logic [hprt_pkg::DT_W-1:0] dt;
		stop_at = items_sent + n_items;
		// frame times scaled so long holds get past the delay and repeat a few times
		dt_hi = int'(period_cfg);
		dt_hi = dt_hi * 2 + 1;
		if (dt_hi < int'(delay_cfg) / 8 + 1)
			dt_hi = int'(delay_cfg) / 8 + 1;
		if (dt_hi > int'(DT_MAX))
			dt_hi = int'(DT_MAX);
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 99) < 15) begin
				send_item(build_item(hprt_pkg::OP_W'($urandom),
					hprt_pkg::ACT_W'($urandom), rnd_bit(), rnd_bit(), rnd_bit(),
					rnd_bit(), rnd_bit(), hprt_pkg::DT_W'($urandom)));
			end else begin
				act = hprt_pkg::ACT_W'($urandom);
				if ($urandom_range(0, 3) == 0)
					send_item(build_item(hprt_pkg::OP_REARM, act, rnd_bit(), rnd_bit(),
						rnd_bit(), rnd_bit(), rnd_bit(), hprt_pkg::DT_W'($urandom)));
				// release first so a suppressed action comes alive
				send_item(build_item(hprt_pkg::OP_TICK, act, 1'b0, rnd_bit(), 1'b1, 1'b0,
					rnd_bit(), hprt_pkg::DT_W'($urandom)));
				len = $urandom_range(1, 40);
				repeat (len) begin
					dt = hprt_pkg::DT_W'(($urandom_range(0, 9) == 0) ? $urandom
						: $urandom_range(0, dt_hi));
					if ($urandom_range(0, 9) == 0)
						send_item(build_item(hprt_pkg::OP_CONSUME, act, rnd_bit(),
							rnd_bit(), rnd_bit(), rnd_bit(), rnd_bit(), dt));
					else
						send_item(build_item(hprt_pkg::OP_TICK, act,
							$urandom_range(0, 19) != 0, rnd_bit(),
							$urandom_range(0, 19) != 0, $urandom_range(0, 19) == 0,
							$urandom_range(0, 9) == 0, dt));
				end
			end
		end
	endtask

	// ---------------------------------------------------------------
	// output side
	// ---------------------------------------------------------------

	// receiver: random stalls, quiet stretches, and long hold-offs on request
	initial begin
		forever begin
			@(negedge clk);
			if (holdoffs_done < holdoff_req) begin
				m_tready <= 1'b0;
				repeat (HOLDOFF_CYCLES) @(negedge clk);
				holdoffs_done++;
			end else if (no_idle) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= 8);
			end
		end
	end

	// result checker: every taken result against the oldest expectation
	always @(posedge clk) begin
		hk_result_t want;
		hk_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.act = m_tdata[4:0];
			got.pressed = m_tdata[5];
			got.pressed_or_repeated = m_tdata[6];
			got.down = m_tdata[7];
			got.consumed = m_tdata[8];
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result item with nothing expected: m_tdata %h", m_tdata);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (got.act !== want.act) begin
					$error("out_action: expected %0d, got %0d", want.act, got.act);
					mismatches++;
				end
				if (got.pressed !== want.pressed) begin
					$error("pressed: expected %0d, got %0d", want.pressed, got.pressed);
					mismatches++;
				end
				if (got.pressed_or_repeated !== want.pressed_or_repeated) begin
					$error("pressed_or_repeated: expected %0d, got %0d",
						want.pressed_or_repeated, got.pressed_or_repeated);
					mismatches++;
				end
				if (got.down !== want.down) begin
					$error("is_down: expected %0d, got %0d", want.down, got.down);
					mismatches++;
				end
				if (got.consumed !== want.consumed) begin
					$error("consumed: expected %0d, got %0d", want.consumed, got.consumed);
					mismatches++;
				end
				if (want.pressed_or_repeated && !want.pressed)
					repeats_seen++;
				if (want.consumed)
					consumes_seen++;
			end
		end
	end

	// run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results still owed", cycle_count,
			pending_results.size());
		$display("RESULT: ERROR");
		$finish;
	end

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// suppression after reset, edges, consume, gating flags, reserved op, rearm
	task automatic test_edge_and_gating();
		// held since reset: kept released
		send_item(build_item(hprt_pkg::OP_TICK, 5'd0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, DT_MAX));
		send_item(build_item(hprt_pkg::OP_CONSUME, 5'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0));
		// first release ends suppression
		send_item(build_item(hprt_pkg::OP_TICK, 5'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, '0));
		send_item(build_item(hprt_pkg::OP_TICK, 5'd0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, DT_MAX));
		// fresh press taken once only
		send_item(build_item(hprt_pkg::OP_CONSUME, 5'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0));
		send_item(build_item(hprt_pkg::OP_CONSUME, 5'd0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
			DT_MAX));
		// past the default delay: repeat, then a zero frame with none
		send_item(build_item(hprt_pkg::OP_TICK, 5'd0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, DT_MAX));
		send_item(build_item(hprt_pkg::OP_TICK, 5'd0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, '0));
		send_item(build_item(OP_RESERVED, 5'd0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, DT_MAX));
		send_item(build_item(hprt_pkg::OP_REARM, 5'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0));
		send_item(build_item(hprt_pkg::OP_TICK, 5'd0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, DT_MAX));
		// gating on the top action: no focus, capture, keyboard while typing
		send_item(build_item(hprt_pkg::OP_TICK, 5'd31, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, '0));
		send_item(build_item(hprt_pkg::OP_TICK, 5'd31, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 20'd1));
		send_item(build_item(hprt_pkg::OP_TICK, 5'd31, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 20'd1));
		send_item(build_item(hprt_pkg::OP_TICK, 5'd31, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 20'd1));
		// typing does not gate a device source
		send_item(build_item(hprt_pkg::OP_TICK, 5'd31, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 20'd1));
		send_item(build_item(hprt_pkg::OP_TICK, 5'd31, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 20'd1));
		send_item(build_item(hprt_pkg::OP_TICK, 5'd31, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
			DT_MAX));
		send_item(build_item(hprt_pkg::OP_REARM, 5'd31, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
			DT_MAX));
	endtask

	task automatic test_default_repeat();
		run_sequences(280);
	endtask

	// long receiver hold-off while items keep coming, so the input backs up
	task automatic test_output_backpressure();
		holdoff_req++;
		run_sequences(100);
	endtask

	// zero delay and zero period, with no idling on either side
	task automatic test_zero_delay_period();
		write_timing('0, '0);
		no_idle = 1'b1;
		run_sequences(200);
		no_idle = 1'b0;
	endtask

	task automatic test_max_timing();
		write_timing('1, '1);
		run_sequences(200);
	endtask

	task automatic test_random_timing();
		write_timing(hprt_pkg::CFG_W'($urandom_range(0, 400000)),
			hprt_pkg::CFG_W'($urandom_range(1, 80000)));
		run_sequences(110);
		write_timing(hprt_pkg::CFG_W'($urandom), hprt_pkg::CFG_W'($urandom));
		run_sequences(110);
		write_timing(hprt_pkg::CFG_W'($urandom_range(0, 2000)),
			hprt_pkg::CFG_W'($urandom_range(0, 500)));
		run_sequences(110);
	endtask

	// one action held at the longest frame with no delay and a period of one,
	// so every tick after the first press repeats while the held time climbs
	task automatic test_long_hold();
		write_timing('0, 24'd1);
		send_item(build_item(hprt_pkg::OP_REARM, 5'd7, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0));
		send_item(build_item(hprt_pkg::OP_TICK, 5'd7, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, '0));
		repeat (150)
			send_item(build_item(hprt_pkg::OP_TICK, 5'd7, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0,
				DT_MAX));
		send_item(build_item(hprt_pkg::OP_TICK, 5'd7, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, DT_MAX));
	endtask

	// ---------------------------------------------------------------
	// sequence of tests
	// ---------------------------------------------------------------

	initial begin
		clear_tracker_state();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_edge_and_gating();
		test_default_repeat();
		test_output_backpressure();
		test_zero_delay_period();
		test_max_timing();
		test_random_timing();
		test_long_hold();

		quiesce();
		$display("covered %0d items and %0d results: %0d repeats, %0d consumes",
			items_sent, results_seen, repeats_seen, consumes_seen);
		$display("timing settings from reset values through zero, random and maximum");
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire
